// ===== sv/vol2col_address_map_defines.svh =====
// Assertion macros shared by the vol2col address mapper RTL.
`ifndef VOL2COL_ADDRESS_MAP_DEFINES_SVH
`define VOL2COL_ADDRESS_MAP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define V2C_ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("vol2col same-cycle check failed");

// Next-cycle implication, checked on aclk outside reset.
`define V2C_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("vol2col next-cycle check failed");

`endif

// ===== sv/v2c_pkg.sv =====
// Package for the vol2col address mapper: widths, register codes, pipeline depths.
package v2c_pkg;

    localparam int DIM_BITS     = 16;
    localparam int ADDRESS_BITS = 40;
    localparam int LANE_BITS    = 16;
    localparam int REG_BITS     = 48;
    localparam int ROW_BITS     = 24;
    localparam int BATCH_BITS   = 16;
    localparam int CHAN_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = ROW_BITS / DIV_STEP;
    localparam int DIV_COUNT  = 3;
    localparam int DIV_LAT    = DIV_STAGES * DIV_COUNT;
    localparam int TAIL_STAGES = 7;
    localparam int PIPE_DEPTH = 1 + DIV_LAT + TAIL_STAGES;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KERNEL_SIZE     = 3'd0,
        REG_PADDING         = 3'd1,
        REG_STRIDE          = 3'd2,
        REG_DILATION        = 3'd3,
        REG_OUTPUT_DIMS     = 3'd4,
        REG_VOLUME_DIMS     = 3'd5,
        REG_SOURCE_CHANNELS = 3'd6,
        REG_COLUMN_ROWS     = 3'd7
    } cfg_index_t;

    localparam logic [REG_BITS-1:0] ONES_RESET = 48'h0001_0001_0001;

    typedef struct packed {
        logic [BATCH_BITS-1:0] batch;
        logic [ROW_BITS-1:0]   row;
        logic [DIM_BITS-1:0]   pd;
        logic [DIM_BITS-1:0]   ph;
        logic [DIM_BITS-1:0]   pw;
    } item_t;

    function automatic logic [DIM_BITS-1:0] lane(input logic [REG_BITS-1:0] r,
                                                 input int unsigned i);
        return r[LANE_BITS*i +: DIM_BITS];
    endfunction

endpackage

// ===== sv/v2c_div.sv =====
// Pipelined restoring divider: row-width dividend by a lane-width divisor held steady.
module v2c_div (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [v2c_pkg::ROW_BITS-1:0] num,
    input  logic [v2c_pkg::DIM_BITS-1:0] den,
    output logic [v2c_pkg::ROW_BITS-1:0] quo,
    output logic [v2c_pkg::DIM_BITS-1:0] rem
);

    // nq holds the dividend bits still to go in its top and quotient bits in its bottom
    logic [v2c_pkg::ROW_BITS-1:0] nq_reg [v2c_pkg::DIV_STAGES];
    logic [v2c_pkg::DIM_BITS-1:0] r_reg  [v2c_pkg::DIV_STAGES];
    logic [v2c_pkg::ROW_BITS-1:0] nq_next [v2c_pkg::DIV_STAGES];
    logic [v2c_pkg::DIM_BITS-1:0] r_next  [v2c_pkg::DIV_STAGES];

    for (genvar s = 0; s < v2c_pkg::DIV_STAGES; s++) begin : g_stage
        always_comb begin
            logic [v2c_pkg::DIM_BITS:0]   t;
            logic [v2c_pkg::ROW_BITS-1:0] nq;
            logic [v2c_pkg::DIM_BITS-1:0] r;
            if (s == 0) begin
                nq = num;
                r  = '0;
            end else begin
                nq = nq_reg[s-1];
                r  = r_reg[s-1];
            end
            for (int k = 0; k < v2c_pkg::DIV_STEP; k++) begin
                t  = {r, nq[v2c_pkg::ROW_BITS-1]};
                nq = {nq[v2c_pkg::ROW_BITS-2:0], 1'b0};
                if (t >= {1'b0, den}) begin
                    t     = t - {1'b0, den};
                    nq[0] = 1'b1;
                end
                r = t[v2c_pkg::DIM_BITS-1:0];
            end
            nq_next[s] = nq;
            r_next[s]  = r;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[s] <= nq_next[s];
                r_reg[s]  <= r_next[s];
            end
        end
    end

    assign quo = nq_reg[v2c_pkg::DIV_STAGES-1];
    assign rem = r_reg[v2c_pkg::DIV_STAGES-1];

endmodule

// ===== sv/vol2col_address_map.sv =====
// vol2col address mapper: one column position in, one source/target address pair out.
//
// Input channel s_*: one item per column-matrix element (batch, kernel row, output
// position). Result channel m_*: source and target word addresses in m_tdata and the
// write enable in m_tuser; a clear enable means the source lies in the padding and the
// target is to be left alone (the source address is then zero).
// The kernel row is split into width, height and depth offsets and a channel by three
// chained pipelined dividers (3 quotient bits per stage, 8 stages each), followed by a
// 7-stage multiply/add tail for coordinates, bounds and addresses.
// An accepted item passes the input register, the three dividers and the tail to m_*.
// Throughput: one item per cycle, sustained while m_tready does not stall the output.
// A stall on m_tready freezes the whole pipeline in place; s_tready drops in the same
// cycle, so nothing is lost or repeated. Results keep input order.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default settings:
// every packed register 1/1/1 except padding 0/0/0, one channel, one column row.
// The configuration port writes one register per cycle with cfg_wr_en; write only while
// no item is in flight.
`include "vol2col_address_map_defines.svh"

module vol2col_address_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [v2c_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [v2c_pkg::REG_BITS-1:0]      cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // batch_index[15:0], kernel_row[39:16], out_depth[55:40], out_height[71:56],
    // out_width[87:72]
    input  logic [87:0]                       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // source_address[39:0], target_address[79:40]
    output logic [2*v2c_pkg::ADDRESS_BITS-1:0] m_tdata,
    // write_enable[0]
    output logic                              m_tuser
);

    localparam int AB = v2c_pkg::ADDRESS_BITS;
    localparam int DB = v2c_pkg::DIM_BITS;
    localparam int PB = 2 * DB;
    localparam int CB = PB + 3;
    localparam int NS = v2c_pkg::PIPE_DEPTH;
    localparam int DS = v2c_pkg::DIV_STAGES;
    localparam int SIDE = 1 + v2c_pkg::DIV_LAT;

    // ---------------- configuration ----------------
    logic [v2c_pkg::REG_BITS-1:0]  kernel_size_reg, padding_reg, stride_reg, dilation_reg;
    logic [v2c_pkg::REG_BITS-1:0]  output_dims_reg, volume_dims_reg;
    logic [v2c_pkg::CHAN_BITS-1:0] source_channels_reg;
    logic [v2c_pkg::ROW_BITS-1:0]  column_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_size_reg     <= v2c_pkg::ONES_RESET;
            padding_reg         <= '0;
            stride_reg          <= v2c_pkg::ONES_RESET;
            dilation_reg        <= v2c_pkg::ONES_RESET;
            output_dims_reg     <= v2c_pkg::ONES_RESET;
            volume_dims_reg     <= v2c_pkg::ONES_RESET;
            source_channels_reg <= v2c_pkg::CHAN_BITS'(1);
            column_rows_reg     <= v2c_pkg::ROW_BITS'(1);
        end else if (cfg_wr_en) begin
            case (v2c_pkg::cfg_index_t'(cfg_addr))
                v2c_pkg::REG_KERNEL_SIZE:     kernel_size_reg <= cfg_wdata;
                v2c_pkg::REG_PADDING:         padding_reg     <= cfg_wdata;
                v2c_pkg::REG_STRIDE:          stride_reg      <= cfg_wdata;
                v2c_pkg::REG_DILATION:        dilation_reg    <= cfg_wdata;
                v2c_pkg::REG_OUTPUT_DIMS:     output_dims_reg <= cfg_wdata;
                v2c_pkg::REG_VOLUME_DIMS:     volume_dims_reg <= cfg_wdata;
                v2c_pkg::REG_SOURCE_CHANNELS:
                    source_channels_reg <= cfg_wdata[v2c_pkg::CHAN_BITS-1:0];
                v2c_pkg::REG_COLUMN_ROWS:
                    column_rows_reg <= cfg_wdata[v2c_pkg::ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // per-lane views: index 0 width, 1 height, 2 depth
    logic [DB-1:0] kern [3];
    logic [DB-1:0] pad  [3];
    logic [DB-1:0] strd [3];
    logic [DB-1:0] dil  [3];
    logic [DB-1:0] vol  [3];
    logic [DB-1:0] odim [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kern[i] = v2c_pkg::lane(kernel_size_reg, i);
            if (kern[i] == '0) kern[i] = DB'(1);
            pad[i]  = v2c_pkg::lane(padding_reg, i);
            strd[i] = v2c_pkg::lane(stride_reg, i);
            dil[i]  = v2c_pkg::lane(dilation_reg, i);
            vol[i]  = v2c_pkg::lane(volume_dims_reg, i);
            odim[i] = v2c_pkg::lane(output_dims_reg, i);
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS-1:0] vld_reg;
    logic          adv;

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    // ---------------- input stage and side data ----------------
    v2c_pkg::item_t in_item;
    v2c_pkg::item_t side_reg [SIDE];

    assign in_item.batch = s_tdata[15:0];
    assign in_item.row   = s_tdata[39:16];
    assign in_item.pd    = s_tdata[40 +: DB];
    assign in_item.ph    = s_tdata[56 +: DB];
    assign in_item.pw    = s_tdata[72 +: DB];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= in_item;
            for (int k = 1; k < SIDE; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------- kernel row split ----------------
    logic [v2c_pkg::ROW_BITS-1:0] q1, q2, chan;
    logic [DB-1:0]                rem_w, rem_h, rem_d;
    logic [DB-1:0]                rw_reg [2*DS];
    logic [DB-1:0]                rh_reg [DS];

    v2c_div u_div_w (.aclk(aclk), .en(adv), .num(side_reg[0].row), .den(kern[0]),
                     .quo(q1), .rem(rem_w));
    v2c_div u_div_h (.aclk(aclk), .en(adv), .num(q1), .den(kern[1]),
                     .quo(q2), .rem(rem_h));
    v2c_div u_div_d (.aclk(aclk), .en(adv), .num(q2), .den(kern[2]),
                     .quo(chan), .rem(rem_d));

    // align earlier remainders with the channel quotient
    always_ff @(posedge aclk) begin
        if (adv) begin
            rw_reg[0] <= rem_w;
            for (int k = 1; k < 2*DS; k++) rw_reg[k] <= rw_reg[k-1];
            rh_reg[0] <= rem_h;
            for (int k = 1; k < DS; k++) rh_reg[k] <= rh_reg[k-1];
        end
    end

    // ---------------- address tail ----------------
    v2c_pkg::item_t it;
    logic [DB-1:0]  off [3];
    logic [DB-1:0]  pos [3];

    assign it     = side_reg[SIDE-1];
    assign off[0] = rw_reg[2*DS-1];
    assign off[1] = rh_reg[DS-1];
    assign off[2] = rem_d;
    assign pos[0] = it.pw;
    assign pos[1] = it.ph;
    assign pos[2] = it.pd;

    // E1
    logic [PB-1:0] e1_pm_reg [3];
    logic [PB-1:0] e1_om_reg [3];
    logic [AB-1:0] e1_cd_reg, e1_bc_reg, e1_rd_reg, e1_bcr_reg;
    logic [DB-1:0] e1_pd_reg, e1_ph_reg, e1_pw_reg;
    // E2
    logic [CB-1:0] e2_c_reg [3];
    logic [AB-1:0] e2_cd_reg, e2_bcv_reg, e2_rdp_reg, e2_bcrd_reg;
    logic [DB-1:0] e2_ph_reg, e2_pw_reg;
    // E3
    logic          e3_in_reg;
    logic [DB-1:0] e3_c1_reg, e3_c0_reg, e3_pw_reg, e3_ph_reg;
    logic [AB-1:0] e3_s1_reg, e3_bcvh_reg, e3_t1_reg, e3_bcrdh_reg;
    // E4
    logic          e4_in_reg;
    logic [DB-1:0] e4_c1_reg, e4_c0_reg, e4_pw_reg;
    logic [AB-1:0] e4_s2_reg, e4_bcvhw_reg, e4_t2_reg, e4_bcrdhw_reg;
    // E5
    logic          e5_in_reg;
    logic [DB-1:0] e5_c0_reg, e5_pw_reg;
    logic [AB-1:0] e5_s3_reg, e5_bcvhw_reg, e5_t3_reg, e5_bcrdhw_reg;
    // E6
    logic          e6_in_reg;
    logic [DB-1:0] e6_c0_reg;
    logic [AB-1:0] e6_s4_reg, e6_bcvhw_reg, e6_t4_reg, e6_bcrdhw_reg;
    // E7 (output)
    logic [AB-1:0] src_reg, dst_reg;
    logic          we_reg;

    logic [2:0]    in_vol;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_vol[i] = !e2_c_reg[i][CB-1] &&
                        (e2_c_reg[i][CB-2:0] < {{(CB-1-DB){1'b0}}, vol[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_pm_reg[i] <= PB'(pos[i] * strd[i]);
                e1_om_reg[i] <= PB'(off[i] * dil[i]);
            end
            e1_cd_reg  <= AB'(chan * vol[2]);
            e1_bc_reg  <= AB'(it.batch * source_channels_reg);
            e1_rd_reg  <= AB'(it.row * odim[2]);
            e1_bcr_reg <= AB'(it.batch * column_rows_reg);
            e1_pd_reg  <= it.pd;
            e1_ph_reg  <= it.ph;
            e1_pw_reg  <= it.pw;

            for (int i = 0; i < 3; i++) begin
                e2_c_reg[i] <= {3'b000, e1_pm_reg[i]} + {3'b000, e1_om_reg[i]}
                               - {{(CB-DB){1'b0}}, pad[i]};
            end
            e2_cd_reg   <= e1_cd_reg;
            e2_bcv_reg  <= AB'(e1_bc_reg * vol[2]);
            e2_rdp_reg  <= e1_rd_reg + {{(AB-DB){1'b0}}, e1_pd_reg};
            e2_bcrd_reg <= AB'(e1_bcr_reg * odim[2]);
            e2_ph_reg   <= e1_ph_reg;
            e2_pw_reg   <= e1_pw_reg;

            // in-volume coordinates are below the lane-width volume size
            e3_in_reg    <= &in_vol;
            e3_c1_reg    <= e2_c_reg[1][DB-1:0];
            e3_c0_reg    <= e2_c_reg[0][DB-1:0];
            e3_s1_reg    <= e2_cd_reg + {{(AB-DB){1'b0}}, e2_c_reg[2][DB-1:0]};
            e3_bcvh_reg  <= AB'(e2_bcv_reg * vol[1]);
            e3_t1_reg    <= AB'(e2_rdp_reg * odim[1]);
            e3_bcrdh_reg <= AB'(e2_bcrd_reg * odim[1]);
            e3_ph_reg    <= e2_ph_reg;
            e3_pw_reg    <= e2_pw_reg;

            e4_in_reg     <= e3_in_reg;
            e4_c1_reg     <= e3_c1_reg;
            e4_c0_reg     <= e3_c0_reg;
            e4_s2_reg     <= AB'(e3_s1_reg * vol[1]);
            e4_bcvhw_reg  <= AB'(e3_bcvh_reg * vol[0]);
            e4_t2_reg     <= e3_t1_reg + {{(AB-DB){1'b0}}, e3_ph_reg};
            e4_bcrdhw_reg <= AB'(e3_bcrdh_reg * odim[0]);
            e4_pw_reg     <= e3_pw_reg;

            e5_in_reg     <= e4_in_reg;
            e5_c0_reg     <= e4_c0_reg;
            e5_s3_reg     <= e4_s2_reg + {{(AB-DB){1'b0}}, e4_c1_reg};
            e5_bcvhw_reg  <= e4_bcvhw_reg;
            e5_t3_reg     <= AB'(e4_t2_reg * odim[0]);
            e5_bcrdhw_reg <= e4_bcrdhw_reg;
            e5_pw_reg     <= e4_pw_reg;

            e6_in_reg     <= e5_in_reg;
            e6_c0_reg     <= e5_c0_reg;
            e6_s4_reg     <= AB'(e5_s3_reg * vol[0]);
            e6_bcvhw_reg  <= e5_bcvhw_reg;
            e6_t4_reg     <= e5_t3_reg + {{(AB-DB){1'b0}}, e5_pw_reg};
            e6_bcrdhw_reg <= e5_bcrdhw_reg;

            src_reg <= e6_in_reg ? e6_bcvhw_reg + e6_s4_reg + {{(AB-DB){1'b0}}, e6_c0_reg}
                                 : '0;
            dst_reg <= e6_bcrdhw_reg + e6_t4_reg;
            we_reg  <= e6_in_reg;
        end
    end

    assign m_tdata = {dst_reg, src_reg};
    assign m_tuser = we_reg;

    `V2C_ASSERT_IMPLY(a_clear_we_zero_src, m_tvalid && !m_tuser, src_reg == '0)
    `V2C_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
    `V2C_ASSERT_NEXT(a_stall_freezes, m_tvalid && !m_tready, vld_reg == $past(vld_reg))
    `V2C_ASSERT_IMPLY(a_rem_below_kernel, vld_reg[DS], rem_w < kern[0])

endmodule
